>>> sv/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared widths, register indexes and format codes of the UTF-8 / UTF-16
// stream transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int UNIT_W  = 16;
  localparam int POINT_W = 21;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int MAX_RUN = 4;
  localparam int CNT_W   = 3;

  typedef logic [UNIT_W-1:0]  unit_t;
  typedef logic [POINT_W-1:0] point_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic {
    FMT_UTF8  = 1'b0,
    FMT_UTF16 = 1'b1
  } fmt_t;

  // register index is paddr[2]
  localparam logic REG_INPUT_FORMAT  = 1'b0;
  localparam logic REG_OUTPUT_FORMAT = 1'b1;

endpackage

>>> sv/u2u_if.sv
// ----------------------------------------------------------------------------
// u2u_if
// Valid/ready channels of the transcoder: one for input units, one for
// output words.
// ----------------------------------------------------------------------------
interface u2u_in_if
  import u2u_pkg::*;
;
  logic  valid;
  logic  ready;
  unit_t unit_in;

  modport source (output valid, output unit_in, input ready);
  modport sink   (input valid, input unit_in, output ready);
endinterface

interface u2u_out_if
  import u2u_pkg::*;
;
  logic   valid;
  logic   ready;
  unit_t  unit_out;
  point_t scalar_value;
  logic   run_end;
  logic   fault;

  modport source (output valid, output unit_out, output scalar_value,
                  output run_end, output fault, input ready);
  modport sink   (input valid, input unit_out, input scalar_value,
                  input run_end, input fault, output ready);
endinterface

>>> sv/utf8_utf16_stream_transcoder.sv
// Output words are registered: the first is valid in the cycle after the input
// unit is accepted. Throughput: one input unit per cycle unless out_ch.ready
// stalls; a code point of n words holds the input while the buffer drains.
// Input ready follows the result buffer: free, or giving up its last word.
// Reset (rst, synchronous): input_format UTF-8, output_format UTF-16,
// partial code point cleared, result buffer empty.
// ----------------------------------------------------------------------------
// utf8_utf16_stream_transcoder
// Decodes UTF-8 bytes or UTF-16 units into code points and re-encodes each
// one as UTF-8 or UTF-16 words, flagging malformed or unencodable input.
// ----------------------------------------------------------------------------
module utf8_utf16_stream_transcoder
  import u2u_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  u2u_in_if.sink             in_ch,
  u2u_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  fmt_t   input_format;
  fmt_t   output_format;
  point_t partial_point;
  logic [1:0] units_pending;
  logic   pair_open;

  unit_t  units [MAX_RUN];
  cnt_t   cnt;
  point_t res_point;
  logic   res_fault;

  logic   cfg_wr;
  logic   in_acc;
  logic   out_take;

  point_t partial_point_next;
  logic [1:0] units_pending_next;
  logic   pair_open_next;
  logic   done;
  logic   bad;
  point_t cp;
  logic [7:0] b;
  logic   sur;

  unit_t  enc [MAX_RUN];
  cnt_t   enc_n;
  logic   enc_bad;
  logic [19:0] v;

  logic   res_any;
  logic   res_flt;
  cnt_t   res_n;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INPUT_FORMAT) ?
                  {{(DATA_W-1){1'b0}}, input_format} :
                  {{(DATA_W-1){1'b0}}, output_format};

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format  <= FMT_UTF8;
      output_format <= FMT_UTF16;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_INPUT_FORMAT) begin
        input_format <= fmt_t'(pwdata[0]);
      end else begin
        output_format <= fmt_t'(pwdata[0]);
      end
    end
  end

  // ---------------------------------------------------------------- handshake
  assign out_take     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (cnt == '0) || ((cnt == cnt_t'(1)) && out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------- decode
  always_comb begin
    b   = in_ch.unit_in[7:0];
    sur = (in_ch.unit_in[15:11] == 5'b11011);
    partial_point_next = partial_point;
    units_pending_next = units_pending;
    pair_open_next     = pair_open;
    done = 1'b0;
    bad  = 1'b0;
    cp   = '0;
    if (input_format == FMT_UTF8) begin
      if (units_pending != 2'd0) begin
        cp = {partial_point[14:0], b[5:0]};
        if (units_pending == 2'd1) begin
          done = 1'b1;
        end
        partial_point_next = cp;
        units_pending_next = units_pending - 2'd1;
      end else if (b < 8'h80) begin
        cp   = {13'd0, b};
        done = 1'b1;
      end else if (b < 8'hC0) begin
        bad = 1'b1;
      end else if (b < 8'hE0) begin
        partial_point_next = {16'd0, b[4:0]};
        units_pending_next = 2'd1;
      end else if (b < 8'hF0) begin
        partial_point_next = {17'd0, b[3:0]};
        units_pending_next = 2'd2;
      end else if (b < 8'hF8) begin
        partial_point_next = {18'd0, b[2:0]};
        units_pending_next = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (pair_open) begin
        if (!sur) begin
          bad = 1'b1;
        end else begin
          cp   = {1'b0, partial_point[9:0], in_ch.unit_in[9:0]} + point_t'(21'h10000);
          done = 1'b1;
        end
      end else if (sur) begin
        partial_point_next = {11'd0, in_ch.unit_in[9:0]};
        pair_open_next     = 1'b1;
      end else begin
        cp   = {5'd0, in_ch.unit_in};
        done = 1'b1;
      end
    end
    if (done || bad) begin
      partial_point_next = '0;
      units_pending_next = 2'd0;
      pair_open_next     = 1'b0;
    end
  end

  // ---------------------------------------------------------------- encode
  always_comb begin
    v       = cp[19:0] - 20'h10000;
    enc_bad = 1'b0;
    enc_n   = cnt_t'(1);
    for (int i = 0; i < MAX_RUN; i++) begin
      enc[i] = '0;
    end
    if (output_format == FMT_UTF8) begin
      if (cp < 21'h80) begin
        enc[0] = {9'd0, cp[6:0]};
      end else if (cp < 21'h800) begin
        enc[0] = {8'd0, 3'b110, cp[10:6]};
        enc[1] = {8'd0, 2'b10, cp[5:0]};
        enc_n  = cnt_t'(2);
      end else if (cp < 21'h10000) begin
        enc[0] = {8'd0, 4'b1110, cp[15:12]};
        enc[1] = {8'd0, 2'b10, cp[11:6]};
        enc[2] = {8'd0, 2'b10, cp[5:0]};
        enc_n  = cnt_t'(3);
      end else begin
        enc[0] = {8'd0, 5'b11110, cp[20:18]};
        enc[1] = {8'd0, 2'b10, cp[17:12]};
        enc[2] = {8'd0, 2'b10, cp[11:6]};
        enc[3] = {8'd0, 2'b10, cp[5:0]};
        enc_n  = cnt_t'(4);
      end
    end else begin
      if ((cp[20:11] == 10'b0000011011) || (cp > 21'h10FFFF)) begin
        enc_bad = 1'b1;
      end else if (cp < 21'h10000) begin
        enc[0] = cp[15:0];
      end else begin
        enc[0] = {6'b110110, v[19:10]};
        enc[1] = {6'b110111, v[9:0]};
        enc_n  = cnt_t'(2);
      end
    end
    res_flt = bad || (done && enc_bad);
    res_any = done || bad;
    res_n   = res_flt ? cnt_t'(1) : enc_n;
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      units_pending <= 2'd0;
      pair_open     <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_INPUT_FORMAT)) begin
      partial_point <= '0;
      units_pending <= 2'd0;
      pair_open     <= 1'b0;
    end else if (in_acc) begin
      partial_point <= partial_point_next;
      units_pending <= units_pending_next;
      pair_open     <= pair_open_next;
    end
  end

  // ---------------------------------------------------------------- result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_acc && res_any) begin
      cnt <= res_n;
    end else if (out_take) begin
      cnt <= cnt - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_any) begin
      for (int i = 0; i < MAX_RUN; i++) begin
        units[i] <= res_flt ? unit_t'(0) : enc[i];
      end
      res_point <= res_flt ? point_t'(0) : cp;
      res_fault <= res_flt;
    end else if (out_take) begin
      for (int i = 0; i < MAX_RUN-1; i++) begin
        units[i] <= units[i+1];
      end
      units[MAX_RUN-1] <= '0;
    end
  end

  assign out_ch.valid        = (cnt != '0);
  assign out_ch.unit_out     = units[0];
  assign out_ch.run_end      = (cnt == cnt_t'(1));
  assign out_ch.scalar_value = (cnt == cnt_t'(1)) ? res_point : point_t'(0);
  assign out_ch.fault        = res_fault;

  // ---------------------------------------------------------------- checks
  a_fault_word: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.fault |->
      out_ch.run_end && (out_ch.unit_out == '0) && (out_ch.scalar_value == '0))
    else $error("fault word not a lone zero word");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (cnt == '0) || ((cnt == cnt_t'(1)) && out_take))
    else $error("input taken while result buffer still busy");

  a_fmt_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && (paddr[2] == REG_INPUT_FORMAT) |=>
      (units_pending == 2'd0) && !pair_open && (partial_point == '0))
    else $error("partial code point kept across input format write");

  a_mode_state: assert property (@(posedge clk) disable iff (rst)
    !((units_pending != 2'd0) && pair_open))
    else $error("UTF-8 and UTF-16 partial state both open");

endmodule
